// ===== hw/rtl/ett_pkg.sv =====
// ett_pkg: shared constants, state type and leaf-to-item mapping for the
// event tournament tree. No dependencies.
`default_nettype none

package ett_pkg;

	localparam int NUM_ITEMS_DEF  = 384;
	localparam int TREE_DEPTH_DEF = 9;
	localparam int TIME_BITS_DEF  = 32;

	// control states of the top level sequencer
	typedef enum logic [1:0] {
		ETT_CLEAR,
		ETT_IDLE,
		ETT_CLIMB,
		ETT_HOLD
	} ett_state_t;

	// item that owns a leaf: single leaves map one to one, the rest in pairs
	function automatic logic [15:0] item_of_leaf(input logic [15:0] leaf,
		input logic [15:0] singles);
		if (leaf < singles) begin
			item_of_leaf = leaf;
		end else begin
			item_of_leaf = singles + ((leaf - singles) >> 1);
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ett_cell.sv =====
// ett_cell: one tree level; stores the entries of its level, reads the
// sibling of each update and hands the winner of the pair to the level above.
// Depends on ett_pkg.
`default_nettype none

module ett_cell
	import ett_pkg::*;
#(
	parameter int NUM_ITEMS  = NUM_ITEMS_DEF,
	parameter int TREE_DEPTH = TREE_DEPTH_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF,
	parameter int LEVEL      = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr_en,
	input  logic [TREE_DEPTH-1:0] clr_addr,
	input  logic                  up_vld,
	input  logic [TREE_DEPTH-1:0] up_pos,
	input  logic [TIME_BITS-1:0]  up_time,
	input  logic [TREE_DEPTH-1:0] up_win,
	output logic                  par_vld,
	output logic [TREE_DEPTH-1:0] par_pos,
	output logic [TIME_BITS-1:0]  par_time,
	output logic [TREE_DEPTH-1:0] par_win
);

	localparam int SIZE    = 1 << LEVEL;
	localparam int SINGLES = 2 * NUM_ITEMS - (1 << TREE_DEPTH);
	localparam int EW      = TIME_BITS + TREE_DEPTH;

	logic [EW-1:0]         mem_q [SIZE];
	logic                  wr_en;
	logic [LEVEL-1:0]      wr_addr;
	logic [EW-1:0]         wr_data;
	logic [TREE_DEPTH-1:0] clr_leaf;
	logic [TREE_DEPTH-1:0] clr_win;
	logic                  vld_s1;
	logic [TREE_DEPTH-1:0] pos_s1;
	logic [TIME_BITS-1:0]  time_s1;
	logic [TREE_DEPTH-1:0] win_s1;
	logic [EW-1:0]         sib_s1;
	logic [TIME_BITS-1:0]  lt, rt, st;
	logic [TREE_DEPTH-1:0] lw, rw, sw;

	// leftmost leaf under the entry being cleared, and the item that owns it
	assign clr_leaf = TREE_DEPTH'(clr_addr[LEVEL-1:0]) << (TREE_DEPTH - LEVEL);
	assign clr_win  = TREE_DEPTH'(item_of_leaf(16'(clr_leaf), 16'(SINGLES)));

	always_comb begin
		if (clr_en) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr[LEVEL-1:0];
			wr_data = {{TIME_BITS{1'b1}}, clr_win};
		end else begin
			wr_en   = up_vld;
			wr_addr = up_pos[LEVEL-1:0];
			wr_data = {up_time, up_win};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		sib_s1  <= mem_q[up_pos[LEVEL-1:0] ^ LEVEL'(1)];
		pos_s1  <= up_pos;
		time_s1 <= up_time;
		win_s1  <= up_win;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= up_vld;
		end
	end

	// even position is the left child; ties go left
	assign st = sib_s1[EW-1:TREE_DEPTH];
	assign sw = sib_s1[TREE_DEPTH-1:0];

	always_comb begin
		if (pos_s1[0]) begin
			lt = st;
			lw = sw;
			rt = time_s1;
			rw = win_s1;
		end else begin
			lt = time_s1;
			lw = win_s1;
			rt = st;
			rw = sw;
		end
		if (lt <= rt) begin
			par_time = lt;
			par_win  = lw;
		end else begin
			par_time = rt;
			par_win  = rw;
		end
	end

	assign par_vld = vld_s1;
	assign par_pos = pos_s1 >> 1;

endmodule

`default_nettype wire

// ===== hw/rtl/event_tournament_tree_core.sv =====
// event_tournament_tree_core: top level; sequencer, update injection, root
// and output register over a chain of ett_cell levels. Depends on ett_pkg, ett_cell.
`default_nettype none

//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------
//  input    | in_valid / in_ready  | item_index, event_time
//  output   | out_valid / out_ready| winner_index, winner_time
//
//  from an accepted beat to out_valid: an item owning one leaf climbs through every
//  cell level, an item owning a leaf pair skips the leaf level, an out of range item
//  skips the climb; each cell registers its winner, then the hold state loads the
//  output register once that is free; in_ready rises again when out_valid is set,
//  so the next beat waits for the whole climb and the hand over
//  after reset a clearing pass writes every level store, in_ready stays low
//  meanwhile
//  one item is in flight at a time; a finished result moves to the output
//  register so the next beat is taken while that result still waits

module event_tournament_tree_core
	import ett_pkg::*;
#(
	parameter int NUM_ITEMS  = NUM_ITEMS_DEF,
	parameter int TREE_DEPTH = TREE_DEPTH_DEF,
	parameter int TIME_BITS  = TIME_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [TREE_DEPTH-1:0] item_index,
	input  logic [TIME_BITS-1:0]  event_time,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TREE_DEPTH-1:0] winner_index,
	output logic [TIME_BITS-1:0]  winner_time
);

	localparam int LEAVES  = 1 << TREE_DEPTH;
	localparam int SINGLES = 2 * NUM_ITEMS - LEAVES;

	ett_state_t state_q, state_nxt;

	logic [TREE_DEPTH-1:0] clr_cnt_q;
	logic                  clr_en;
	logic                  in_acc;
	logic                  in_range;
	logic                  is_single;
	logic                  inj_leaf_vld;
	logic                  inj_pair_vld;
	logic [TREE_DEPTH-1:0] pair_pos;
	logic                  load_out;
	logic [TIME_BITS-1:0]  root_time_q;
	logic [TREE_DEPTH-1:0] root_win_q;
	logic                  out_valid_q;
	logic [TIME_BITS-1:0]  out_time_q;
	logic [TREE_DEPTH-1:0] out_win_q;

	// per level: update going in, winner coming out
	logic                  up_vld   [1:TREE_DEPTH];
	logic [TREE_DEPTH-1:0] up_pos   [1:TREE_DEPTH];
	logic [TIME_BITS-1:0]  up_time  [1:TREE_DEPTH];
	logic [TREE_DEPTH-1:0] up_win   [1:TREE_DEPTH];
	logic                  par_vld  [1:TREE_DEPTH];
	logic [TREE_DEPTH-1:0] par_pos  [1:TREE_DEPTH];
	logic [TIME_BITS-1:0]  par_time [1:TREE_DEPTH];
	logic [TREE_DEPTH-1:0] par_win  [1:TREE_DEPTH];

	// decode of the incoming beat
	assign in_acc    = in_valid && in_ready;
	assign in_range  = {1'b0, item_index} < (TREE_DEPTH + 1)'(NUM_ITEMS);
	assign is_single = {1'b0, item_index} < (TREE_DEPTH + 1)'(SINGLES);

	// single leaf items enter at the leaf level; a pair item's two leaves
	// always sit under one node, so it enters one level higher
	assign inj_leaf_vld = in_acc && in_range && is_single;
	assign inj_pair_vld = in_acc && in_range && !is_single;
	assign pair_pos     = item_index - TREE_DEPTH'(SINGLES / 2);

	assign clr_en = (state_q == ETT_CLEAR);

	generate
		for (genvar k = 1; k <= TREE_DEPTH; k++) begin : g_level
			if (k == TREE_DEPTH) begin : g_leaf
				assign up_vld[k]  = inj_leaf_vld;
				assign up_pos[k]  = item_index;
				assign up_time[k] = event_time;
				assign up_win[k]  = item_index;
			end else if (k == TREE_DEPTH - 1) begin : g_pair
				assign up_vld[k]  = inj_pair_vld || par_vld[k+1];
				assign up_pos[k]  = inj_pair_vld ? pair_pos : par_pos[k+1];
				assign up_time[k] = inj_pair_vld ? event_time : par_time[k+1];
				assign up_win[k]  = inj_pair_vld ? item_index : par_win[k+1];
			end else begin : g_node
				assign up_vld[k]  = par_vld[k+1];
				assign up_pos[k]  = par_pos[k+1];
				assign up_time[k] = par_time[k+1];
				assign up_win[k]  = par_win[k+1];
			end

			ett_cell #(
				.NUM_ITEMS  (NUM_ITEMS),
				.TREE_DEPTH (TREE_DEPTH),
				.TIME_BITS  (TIME_BITS),
				.LEVEL      (k)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.clr_en   (clr_en),
				.clr_addr (clr_cnt_q),
				.up_vld   (up_vld[k]),
				.up_pos   (up_pos[k]),
				.up_time  (up_time[k]),
				.up_win   (up_win[k]),
				.par_vld  (par_vld[k]),
				.par_pos  (par_pos[k]),
				.par_time (par_time[k]),
				.par_win  (par_win[k])
			);
		end
	endgenerate

	// sequencer: clearing pass, idle, climb, hand over to output register
	always_comb begin
		state_nxt = state_q;
		load_out  = 1'b0;
		in_ready  = 1'b0;
		case (state_q)
			ETT_CLEAR: begin
				if (&clr_cnt_q) begin
					state_nxt = ETT_IDLE;
				end
			end
			ETT_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					// out of range beats leave the tree alone
					state_nxt = in_range ? ETT_CLIMB : ETT_HOLD;
				end
			end
			ETT_CLIMB: begin
				if (par_vld[1]) begin
					state_nxt = ETT_HOLD;
				end
			end
			ETT_HOLD: begin
				if (!out_valid_q || out_ready) begin
					load_out  = 1'b1;
					state_nxt = ETT_IDLE;
				end
			end
			default: begin
				state_nxt = ETT_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ETT_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (clr_en) begin
				clr_cnt_q <= clr_cnt_q + TREE_DEPTH'(1);
			end
		end
	end

	// root entry: after reset the latest time, owned by item 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_time_q <= '1;
			root_win_q  <= '0;
		end else if (par_vld[1]) begin
			root_time_q <= par_time[1];
			root_win_q  <= par_win[1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_time_q <= root_time_q;
			out_win_q  <= root_win_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign winner_index = out_win_q;
	assign winner_time  = out_time_q;

endmodule

`default_nettype wire
